@@ rtl/mpr_pkg.sv @@
// ----------------------------------------------------------------------------
// mpr_pkg: shared types for the mesh ping responder
// Holds the request, result and register-set types and the request codes
// used by the top level and the ping engine.
// ----------------------------------------------------------------------------
package mpr_pkg;

   // Widths of the stream payloads.
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned ReqUserWidth = 2;
   localparam int unsigned RspDataWidth = 48;
   localparam int unsigned RspUserWidth = 4;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 16;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxWidth-1:0] REG_MY_NODE         = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_ACK_TIMEOUT     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_MAX_RETRIES     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_RETRY_GAP       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_DIR_TO_CHILDREN = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_DIR_TO_PARENT   = 3'd5;
   localparam logic [CsrIdxWidth-1:0] REG_DIR_TO_OTHERS   = 3'd6;

   // Request kinds carried in the func field.
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_FRAME  = 2'd1;
   localparam logic [1:0] FUNC_START  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Upper nibble of the frame flags.
   localparam logic [3:0] KIND_REQUEST  = 4'hf;
   localparam logic [3:0] KIND_RESPONSE = 4'h0;

   // One incoming request.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] frame_dst;
      logic [7:0] frame_src;
      logic [7:0] frame_flags;
      logic [7:0] target_node;
      logic [3:0] target_direction;
   } item_type;

   // One result item.
   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_node;
      logic [7:0] send_flags;
      logic       parent_valid;
      logic [7:0] parent_node;
      logic       route_valid;
      logic [7:0] route_index;
      logic [7:0] route_value;
      logic       ping_done;
      logic [7:0] ping_result;
   } result_type;

   // Configuration register set.
   typedef struct packed {
      logic [7:0]  my_node;
      logic [7:0]  ack_timeout;
      logic [7:0]  max_retries;
      logic [15:0] retry_gap;
      logic [3:0]  dir_to_children;
      logic [3:0]  dir_to_parent;
      logic [3:0]  dir_to_others;
   } cfg_type;

endpackage

@@ rtl/mpr_engine.sv @@
// ----------------------------------------------------------------------------
// mpr_engine: ping state and single-pass request decode
// Decodes one registered request against the ping state, forms its result
// and updates the state when the request is retired.
// ----------------------------------------------------------------------------
module mpr_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  mpr_pkg::item_type  item,
   input  mpr_pkg::cfg_type   cfg,
   output mpr_pkg::result_type res,
   output logic               has_result
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_GAP  = 2'd2;

   localparam logic [7:0] RESULT_FAIL   = 8'hff;
   localparam logic [15:0] LAT_MAX      = 16'd254;

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  target_ff, target_in;
   logic [3:0]  direction_ff, direction_in;
   logic [7:0]  retries_ff, retries_in;

   logic [3:0]  kind;
   logic [3:0]  dir;
   logic [15:0] latency;

   assign kind    = item.frame_flags[7:4];
   assign dir     = item.frame_flags[3:0];
   assign latency = (elapsed_ff > LAT_MAX) ? LAT_MAX : elapsed_ff;

   // Result and next state for the request held at the input register.
   always_comb begin
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      target_in    = target_ff;
      direction_in = direction_ff;
      retries_in   = retries_ff;
      res          = '0;
      case (item.func)
         mpr_pkg::FUNC_TICK: begin
            if (phase_ff == PH_WAIT) begin
               if (elapsed_ff >= {8'd0, cfg.ack_timeout}) begin
                  elapsed_in = '0;
                  if (retries_ff == 8'd0) begin
                     phase_in      = PH_IDLE;
                     res.ping_done   = 1'b1;
                     res.ping_result = RESULT_FAIL;
                  end else begin
                     phase_in = PH_GAP;
                  end
               end else begin
                  elapsed_in = elapsed_ff + 16'd1;
               end
            end else if (phase_ff == PH_GAP) begin
               if (elapsed_ff >= cfg.retry_gap) begin
                  retries_in     = retries_ff - 8'd1;
                  phase_in       = PH_WAIT;
                  elapsed_in     = '0;
                  res.send_valid = 1'b1;
                  res.send_node  = target_ff;
                  res.send_flags = {mpr_pkg::KIND_REQUEST, direction_ff};
               end else begin
                  elapsed_in = elapsed_ff + 16'd1;
               end
            end
         end
         mpr_pkg::FUNC_FRAME: begin
            if (item.frame_dst == cfg.my_node) begin
               if (kind == mpr_pkg::KIND_REQUEST) begin
                  // Answer the request; the reply direction follows its origin.
                  res.send_valid = 1'b1;
                  res.send_node  = item.frame_src;
                  if (dir == cfg.dir_to_children) begin
                     res.send_flags   = {4'd0, cfg.dir_to_parent};
                     res.parent_valid = 1'b1;
                     res.parent_node  = item.frame_src;
                  end else if (dir == cfg.dir_to_parent) begin
                     res.send_flags  = {4'd0, cfg.dir_to_children};
                     res.route_valid = 1'b1;
                     res.route_index = item.frame_src;
                     res.route_value = cfg.my_node;
                  end else begin
                     res.send_flags = {4'd0, cfg.dir_to_others};
                  end
               end else if (kind == mpr_pkg::KIND_RESPONSE && phase_ff == PH_WAIT &&
                            item.frame_src == target_ff) begin
                  phase_in        = PH_IDLE;
                  elapsed_in      = '0;
                  res.ping_done   = 1'b1;
                  res.ping_result = latency[7:0];
               end
            end else if (dir == cfg.dir_to_children) begin
               // Overheard frame toward children teaches a neighbor entry.
               res.route_valid = 1'b1;
               res.route_index = item.frame_dst;
               res.route_value = item.frame_src;
            end
         end
         mpr_pkg::FUNC_START: begin
            target_in      = item.target_node;
            direction_in   = item.target_direction;
            retries_in     = cfg.max_retries;
            phase_in       = PH_WAIT;
            elapsed_in     = '0;
            res.send_valid = 1'b1;
            res.send_node  = item.target_node;
            res.send_flags = {mpr_pkg::KIND_REQUEST, item.target_direction};
         end
         default: begin
         end
      endcase
   end

   assign has_result = res.send_valid | res.parent_valid | res.route_valid | res.ping_done;

   // Ping state is updated only when the request retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         target_ff    <= '0;
         direction_ff <= '0;
         retries_ff   <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         target_ff    <= target_in;
         direction_ff <= direction_in;
         retries_ff   <= retries_in;
      end
   end

endmodule

@@ rtl/mesh_ping_responder_and_retry.sv @@
// ----------------------------------------------------------------------------
// mesh_ping_responder_and_retry: short-ping handling for one mesh node
// Answers ping requests, learns routes from ping traffic and runs one
// outgoing ping with timeout and retries.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while no request is held,
// whether it is a millisecond tick, a received ping frame or a start-ping
// command. A request goes into an input register, is decoded against the ping
// state in one pass, and its result, if it has one, is written to the output
// register when the request retires. The output register lets a new request in
// while a result waits for the sink; a request is held only when it has a
// result and the output register is still full. Requests that cause no result
// retire silently. Registers are written through the csr_ port, which is
// always ready; write them only while no request is in flight.
module mesh_ping_responder_and_retry (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: frame_dst[7:0], frame_src[15:8], frame_flags[23:16],
   //        target_node[31:24], target_direction[35:32], zero pad[39:36]
   input  logic [mpr_pkg::ReqDataWidth-1:0] req_tdata,
   // tuser: func[1:0]
   input  logic [mpr_pkg::ReqUserWidth-1:0] req_tuser,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: send_node[7:0], send_flags[15:8], parent_node[23:16],
   //        route_index[31:24], route_value[39:32], ping_result[47:40]
   output logic [mpr_pkg::RspDataWidth-1:0] rsp_tdata,
   // tuser: send_valid[0], parent_valid[1], route_valid[2], ping_done[3]
   output logic [mpr_pkg::RspUserWidth-1:0] rsp_tuser,
   // Register write port.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mpr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [mpr_pkg::CsrDataWidth-1:0] csr_data
);

   mpr_pkg::cfg_type    cfg_ff;
   mpr_pkg::item_type   s1_item_ff;
   logic                s1_valid_ff;
   mpr_pkg::result_type rsp_res_ff;
   logic                rsp_valid_ff;

   mpr_pkg::result_type res;
   logic                has_result;
   logic                out_free;
   logic                fire;
   logic                csr_write;

   // Configuration registers.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.my_node         <= 8'd0;
         cfg_ff.ack_timeout     <= 8'd5;
         cfg_ff.max_retries     <= 8'd3;
         cfg_ff.retry_gap       <= 16'd100;
         cfg_ff.dir_to_children <= 4'd1;
         cfg_ff.dir_to_parent   <= 4'd2;
         cfg_ff.dir_to_others   <= 4'd3;
      end else if (csr_write) begin
         case (csr_index)
            mpr_pkg::REG_MY_NODE:         cfg_ff.my_node         <= csr_data[7:0];
            mpr_pkg::REG_ACK_TIMEOUT:     cfg_ff.ack_timeout     <= csr_data[7:0];
            mpr_pkg::REG_MAX_RETRIES:     cfg_ff.max_retries     <= csr_data[7:0];
            mpr_pkg::REG_RETRY_GAP:       cfg_ff.retry_gap       <= csr_data;
            mpr_pkg::REG_DIR_TO_CHILDREN: cfg_ff.dir_to_children <= csr_data[3:0];
            mpr_pkg::REG_DIR_TO_PARENT:   cfg_ff.dir_to_parent   <= csr_data[3:0];
            mpr_pkg::REG_DIR_TO_OTHERS:   cfg_ff.dir_to_others   <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the held request retires unless its result finds the
   // output register occupied.
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign fire       = s1_valid_ff & (~has_result | out_free);
   assign req_tready = ~s1_valid_ff | fire;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         s1_item_ff.func             <= req_tuser;
         s1_item_ff.frame_dst        <= req_tdata[7:0];
         s1_item_ff.frame_src        <= req_tdata[15:8];
         s1_item_ff.frame_flags      <= req_tdata[23:16];
         s1_item_ff.target_node      <= req_tdata[31:24];
         s1_item_ff.target_direction <= req_tdata[35:32];
      end
   end

   mpr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .res        (res),
      .has_result (has_result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire & has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (fire & has_result) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_res_ff.ping_result, rsp_res_ff.route_value,
                        rsp_res_ff.route_index, rsp_res_ff.parent_node,
                        rsp_res_ff.send_flags, rsp_res_ff.send_node};
   assign rsp_tuser  = {rsp_res_ff.ping_done, rsp_res_ff.route_valid,
                        rsp_res_ff.parent_valid, rsp_res_ff.send_valid};

endmodule

@@ rtl/mpr_checker.sv @@
// ----------------------------------------------------------------------------
// mpr_checker: port-level checks for the mesh ping responder
// Watches the result channel and flags malformed or unstable results.
// ----------------------------------------------------------------------------
module mpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // A stalled result keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Every delivered result carries at least one action.
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 4'd0)
      else $error("empty result delivered");

   // A finished ping is reported on its own.
   a_done_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser == 4'b1000)
      else $error("ping report mixed with other actions");

   // A parent update only comes with a reply frame, never with a routing update.
   a_update_with_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && !rsp_tuser[2])
      else $error("parent update without reply");

   // Nothing is delivered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind mesh_ping_responder_and_retry mpr_checker u_mpr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
